FILE: sv/fdc_pkg.sv
// Shared types and constants for the STX/ETX frame receiver with CRC-32 check.
`timescale 1ns / 1ps

package fdc_pkg;

  localparam logic [7:0]  BYTE_STX      = 8'h02;
  localparam logic [7:0]  BYTE_ETX      = 8'h03;
  localparam logic [7:0]  BYTE_ACK      = 8'hFF;
  localparam logic [7:0]  BYTE_NACK     = 8'hFE;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
  localparam logic [2:0]  CRC_BYTES     = 3'd4;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'd0,
    PH_FDEST  = 4'd1,
    PH_NHOP   = 4'd2,
    PH_SRC    = 4'd3,
    PH_TTL    = 4'd4,
    PH_LEN    = 4'd5,
    PH_DATA   = 4'd6,
    PH_CRC    = 4'd7,
    PH_ETX    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_GOOD      = 3'd2,
    EV_CRC_ERR   = 3'd3,
    EV_FRAME_ERR = 3'd4,
    EV_TIMEOUT   = 3'd5,
    EV_NOT_ADDR  = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NACK = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef enum logic [0:0] {
    CFG_MY_ID        = 1'b0,
    CFG_BYTE_TIMEOUT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [0:0] req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_kind;
    logic [7:0] final_dest;
    logic [7:0] source_node;
    logic [7:0] hops_left;
    logic [7:0] payload_length;
    logic       forward_needed;
  } res_t;

endpackage

FILE: sv/frame_deframer_crc32.sv
// Top level of the STX/ETX frame receiver with CRC-32 check.
//
// Usage: each request on the req channel is either a received byte or a
// one millisecond tick. Every accepted request yields exactly one result on
// the res channel: event none, a payload byte with its index, or a frame
// outcome (good, CRC error, framing error, timeout, not addressed); good, CRC
// error and not addressed carry the header fields, frame kind and forward flag.
// Registers: the request is captured in the input register when accepted and
// its result in the output register when it steps; a result stall can hold it between.
// Throughput: one request per cycle while no result is stalled; the byte-wide CRC
// update and phase machine sit in the single stage between the two registers.
// Stall: when res_stall holds a waiting result, the input register keeps
// one more request and then req_stall rises until the result is taken.
// Configuration: cfg_ready is always high; write my_id (index 0) and
// byte_timeout (index 1) only while no request is in flight.
// Reset (rst, synchronous): empties both registers, returns the receiver to
// the start-byte search, my_id to 0 and byte_timeout to 500.
`timescale 1ns / 1ps

module frame_deframer_crc32 (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  fdc_pkg::req_t       req,
  output logic                res_valid,
  input  logic                res_stall,
  output fdc_pkg::res_t       res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  fdc_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data
);

  logic          req_q_valid;
  fdc_pkg::req_t req_q;
  logic          advance;
  logic          step;
  fdc_pkg::res_t res_comb;
  logic [7:0]    my_id;
  logic [15:0]   byte_timeout;

  assign cfg_ready = 1'b1;
  assign advance   = !res_valid || !res_stall;
  assign step      = req_q_valid && advance;
  assign req_stall = req_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_id        <= 8'd0;
      byte_timeout <= fdc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdc_pkg::CFG_MY_ID:        my_id        <= cfg_data[7:0];
        fdc_pkg::CFG_BYTE_TIMEOUT: byte_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_q_valid <= 1'b1;
    end else if (advance) begin
      req_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  fdc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .req          (req_q),
    .my_id        (my_id),
    .byte_timeout (byte_timeout),
    .res          (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_comb;
    end
  end

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> res_valid)
    else $error("processed request produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (res_valid && res_stall && req_q_valid))
    else $error("input stalled while the pipeline can move");

endmodule

FILE: sv/fdc_crc32_byte.sv
// Byte-wide update of the reflected CRC-32.
`timescale 1ns / 1ps

module fdc_crc32_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_byte,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_byte};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ fdc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: sv/fdc_parser.sv
// Frame parser: phase machine, header capture, CRC check, timeout and result forming.
`timescale 1ns / 1ps

module fdc_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  fdc_pkg::req_t req,
  input  logic [7:0]   my_id,
  input  logic [15:0]  byte_timeout,
  output fdc_pkg::res_t res
);

  fdc_pkg::phase_t phase, phase_next;
  logic [31:0] crc_acc, crc_acc_next, crc_upd;
  logic [31:0] received_crc, received_crc_next;
  logic [2:0]  crc_byte_count, crc_byte_count_next;
  logic [7:0]  final_dest_reg, final_dest_reg_next;
  logic [7:0]  next_hop_reg, next_hop_reg_next;
  logic [7:0]  source_reg, source_reg_next;
  logic [7:0]  ttl_reg, ttl_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  data_count, data_count_next;
  logic [7:0]  first_payload, first_payload_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  logic        is_tick;
  logic [7:0]  b;
  logic        active;
  logic [15:0] idle_inc;
  logic        timed_out;
  logic [7:0]  data_inc;
  logic [2:0]  crc_cnt_inc;
  logic        restart;
  fdc_pkg::kind_t kind;

  fdc_crc32_byte u_crc (
    .crc_in    (crc_acc),
    .data_byte (b),
    .crc_out   (crc_upd)
  );

  assign is_tick     = (req.req_type == fdc_pkg::REQ_TICK);
  assign b           = req.rx_byte;
  assign active      = (phase != fdc_pkg::PH_SEARCH) && (phase <= fdc_pkg::PH_ETX);
  assign idle_inc    = (idle_ticks == fdc_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;
  assign timed_out   = is_tick && active && (idle_inc > byte_timeout);
  assign data_inc    = data_count + 8'd1;
  assign crc_cnt_inc = crc_byte_count + 3'd1;

  always_comb begin
    if (length_reg == 8'd0) begin
      kind = fdc_pkg::KIND_DATA;
    end else if (first_payload == fdc_pkg::BYTE_ACK) begin
      kind = fdc_pkg::KIND_ACK;
    end else if (first_payload == fdc_pkg::BYTE_NACK) begin
      kind = fdc_pkg::KIND_NACK;
    end else begin
      kind = fdc_pkg::KIND_DATA;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      if (timed_out) begin
        phase_next = fdc_pkg::PH_SEARCH;
      end
    end else begin
      unique case (phase)
        fdc_pkg::PH_FDEST: phase_next = fdc_pkg::PH_NHOP;
        fdc_pkg::PH_NHOP:  phase_next = fdc_pkg::PH_SRC;
        fdc_pkg::PH_SRC:   phase_next = fdc_pkg::PH_TTL;
        fdc_pkg::PH_TTL:   phase_next = fdc_pkg::PH_LEN;
        fdc_pkg::PH_LEN:   phase_next = (b == 8'd0) ? fdc_pkg::PH_CRC : fdc_pkg::PH_DATA;
        fdc_pkg::PH_DATA:  phase_next = (data_inc == length_reg) ? fdc_pkg::PH_CRC
                                                                   : fdc_pkg::PH_DATA;
        fdc_pkg::PH_CRC:   phase_next = (crc_cnt_inc >= fdc_pkg::CRC_BYTES) ? fdc_pkg::PH_ETX
                                                                            : fdc_pkg::PH_CRC;
        fdc_pkg::PH_ETX:   phase_next = fdc_pkg::PH_SEARCH;
        default:           phase_next = (b == fdc_pkg::BYTE_STX) ? fdc_pkg::PH_FDEST
                                                                  : fdc_pkg::PH_SEARCH;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    crc_acc_next        = crc_acc;
    received_crc_next   = received_crc;
    crc_byte_count_next = crc_byte_count;
    final_dest_reg_next = final_dest_reg;
    next_hop_reg_next   = next_hop_reg;
    source_reg_next     = source_reg;
    ttl_reg_next        = ttl_reg;
    length_reg_next     = length_reg;
    data_count_next     = data_count;
    first_payload_next  = first_payload;
    idle_ticks_next     = idle_ticks;
    restart             = 1'b0;
    res                 = '0;
    res.event_res       = fdc_pkg::EV_NONE;

    if (is_tick) begin
      if (active) begin
        idle_ticks_next = idle_inc;
      end
      if (timed_out) begin
        restart       = 1'b1;
        res.event_res = fdc_pkg::EV_TIMEOUT;
      end
    end else begin
      idle_ticks_next = 16'd0;
      unique case (phase)
        fdc_pkg::PH_FDEST: begin
          crc_acc_next        = crc_upd;
          final_dest_reg_next = b;
        end
        fdc_pkg::PH_NHOP: begin
          crc_acc_next      = crc_upd;
          next_hop_reg_next = b;
        end
        fdc_pkg::PH_SRC: begin
          crc_acc_next    = crc_upd;
          source_reg_next = b;
        end
        fdc_pkg::PH_TTL: begin
          crc_acc_next = crc_upd;
          ttl_reg_next = b;
        end
        fdc_pkg::PH_LEN: begin
          crc_acc_next    = crc_upd;
          length_reg_next = b;
          data_count_next = 8'd0;
        end
        fdc_pkg::PH_DATA: begin
          crc_acc_next = crc_upd;
          if (data_count == 8'd0) begin
            first_payload_next = b;
          end
          res.event_res     = fdc_pkg::EV_PAYLOAD;
          res.payload_byte  = b;
          res.payload_index = data_count;
          data_count_next   = data_inc;
        end
        fdc_pkg::PH_CRC: begin
          received_crc_next   = received_crc | ({24'd0, b} << {crc_byte_count[1:0], 3'b000});
          crc_byte_count_next = crc_cnt_inc;
        end
        fdc_pkg::PH_ETX: begin
          restart = 1'b1;
          if (b != fdc_pkg::BYTE_ETX) begin
            res.event_res = fdc_pkg::EV_FRAME_ERR;
          end else begin
            if (next_hop_reg != my_id) begin
              res.event_res = fdc_pkg::EV_NOT_ADDR;
            end else if (received_crc != ~crc_acc) begin
              res.event_res = fdc_pkg::EV_CRC_ERR;
            end else begin
              res.event_res = fdc_pkg::EV_GOOD;
            end
            res.frame_kind     = kind;
            res.final_dest     = final_dest_reg;
            res.source_node    = source_reg;
            res.hops_left      = ttl_reg;
            res.payload_length = length_reg;
            res.forward_needed = (res.event_res == fdc_pkg::EV_GOOD) &&
                                 (kind == fdc_pkg::KIND_DATA) && (final_dest_reg != my_id);
          end
        end
        default: begin
          restart = 1'b1;
          if (b == fdc_pkg::BYTE_STX) begin
            first_payload_next = 8'd0;
          end else begin
            res.event_res = fdc_pkg::EV_FRAME_ERR;
          end
        end
      endcase
    end

    if (restart) begin
      crc_acc_next        = fdc_pkg::CRC_INIT;
      received_crc_next   = 32'd0;
      crc_byte_count_next = 3'd0;
      data_count_next     = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= fdc_pkg::PH_SEARCH;
      crc_acc        <= fdc_pkg::CRC_INIT;
      received_crc   <= 32'd0;
      crc_byte_count <= 3'd0;
      final_dest_reg <= 8'd0;
      next_hop_reg   <= 8'd0;
      source_reg     <= 8'd0;
      ttl_reg        <= 8'd0;
      length_reg     <= 8'd0;
      data_count     <= 8'd0;
      first_payload  <= 8'd0;
      idle_ticks     <= 16'd0;
    end else if (step) begin
      phase          <= phase_next;
      crc_acc        <= crc_acc_next;
      received_crc   <= received_crc_next;
      crc_byte_count <= crc_byte_count_next;
      final_dest_reg <= final_dest_reg_next;
      next_hop_reg   <= next_hop_reg_next;
      source_reg     <= source_reg_next;
      ttl_reg        <= ttl_reg_next;
      length_reg     <= length_reg_next;
      data_count     <= data_count_next;
      first_payload  <= first_payload_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

  a_crc_count_bound: assert property (@(posedge clk) disable iff (rst)
    crc_byte_count <= fdc_pkg::CRC_BYTES)
    else $error("crc byte count beyond four");

  a_etx_after_crc: assert property (@(posedge clk) disable iff (rst)
    phase == fdc_pkg::PH_ETX |-> crc_byte_count == fdc_pkg::CRC_BYTES)
    else $error("ETX phase without four CRC bytes");

endmodule
